FILE: rtl/bpa_pkg.sv
// bpa_pkg: shared constants, status and operation codes of the page allocator
// depends on nothing; imported by the interfaces, the control logic, the register
// block and the checker
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam int DEF_PAGE_COUNT     = 4096;
	localparam int DEF_PAGE_BYTES     = 4096;
	localparam int DEF_RESERVED_PAGES = 256;

	localparam int ADDR_W   = 48;
	localparam int STATUS_W = 3;
	localparam int FREE_W   = 25;
	localparam int USED_W   = 13;
	localparam int WORD_W   = 64;

	// configuration port
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;
	localparam logic REG_BASE_ADDRESS = 1'b0;
	localparam logic [ADDR_W-1:0] BASE_RESET = 48'h0000_0010_0000;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OOM     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BELOW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/bpa_req_if.sv
// bpa_req_if: request channel of the page allocator (valid, ready, payload)
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if import bpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, output operation, output free_address, input ready);
	modport sink   (input valid, input operation, input free_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpa_rsp_if.sv
// bpa_rsp_if: result channel of the page allocator (valid, ready, payload)
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bpa_rsp_if import bpa_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   page_address;
	logic [STATUS_W-1:0] status;
	logic [FREE_W-1:0]   free_bytes;

	modport source (output valid, output page_address, output status, output free_bytes,
		input ready);
	modport sink   (input valid, input page_address, input status, input free_bytes,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/bpa_ram.sv
// bpa_ram: generic simple dual-port RAM, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bpa_cfg.sv
// bpa_cfg: APB-style register block holding the base address of the region
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpa_cfg import bpa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [ADDR_W-1:0]     base
);

	logic [ADDR_W-1:0] base_q;
	logic              hit;

	// registers sit on 8-byte boundaries, low address bits ignored
	assign hit    = (paddr[CFG_ADDR_W-1] == REG_BASE_ADDRESS);
	assign pready = 1'b1;
	assign base   = base_q;
	assign prdata = hit ? CFG_DATA_W'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			base_q <= pwdata[ADDR_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bpa_ctrl.sv
// bpa_ctrl: sequencer of the page allocator; sweeps, scans and updates the used map
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if; drives the ports of one bpa_ram
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl import bpa_pkg::*; #(
	parameter int PAGE_COUNT     = DEF_PAGE_COUNT,
	parameter int PAGE_BYTES     = DEF_PAGE_BYTES,
	parameter int RESERVED_PAGES = DEF_RESERVED_PAGES
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic [ADDR_W-1:0]                        base,
	bpa_req_if.sink                                       req,
	bpa_rsp_if.source                                     rsp,
	output logic                                          ram_we,
	output logic      [$clog2(PAGE_COUNT/WORD_W)-1:0]     ram_waddr,
	output logic      [WORD_W-1:0]                        ram_wdata,
	output logic                                          ram_re,
	output logic      [$clog2(PAGE_COUNT/WORD_W)-1:0]     ram_raddr,
	input  wire logic [WORD_W-1:0]                        ram_rdata
);

	localparam int MAP_WORDS = PAGE_COUNT / WORD_W;
	localparam int WA_W      = $clog2(MAP_WORDS);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int HIT_W     = WA_W + BIT_W;
	localparam int IDX_W     = $clog2(PAGE_COUNT);
	localparam int PB_SH     = $clog2(PAGE_BYTES);
	localparam int FP_W      = IDX_W + 1;
	localparam int RES_EFF   = (RESERVED_PAGES < PAGE_COUNT) ? RESERVED_PAGES : PAGE_COUNT;
	localparam bit NO_SCAN   = (RES_EFF >= PAGE_COUNT);

	localparam logic [WA_W-1:0]   START_WORD = WA_W'(NO_SCAN ? 0 : RES_EFF / WORD_W);
	localparam logic [WA_W-1:0]   LAST_WORD  = WA_W'(MAP_WORDS - 1);
	localparam logic [WORD_W-1:0] START_MASK =
		(WORD_W'(1) << (RES_EFF % WORD_W)) - WORD_W'(1);
	localparam logic [ADDR_W-1:0] REGION_BYTES = ADDR_W'(64'(PAGE_COUNT) * 64'(PAGE_BYTES));
	localparam logic [IDX_W:0]    RES_EFF_V    = (IDX_W+1)'(RES_EFF);
	localparam logic [USED_W-1:0] USED_RESET   = USED_W'(RES_EFF);

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_ALLOC    = 3'd3;
	localparam logic [2:0] S_FREE_CHK = 3'd4;
	localparam logic [2:0] S_FREE_RD  = 3'd5;
	localparam logic [2:0] S_EMIT     = 3'd6;

	function automatic logic [WORD_W-1:0] reset_word(input logic [WA_W-1:0] w);
		logic [WORD_W-1:0] r;
		logic [IDX_W:0]    pg;
		for (int b = 0; b < WORD_W; b++) begin
			pg   = (IDX_W+1)'({w, BIT_W'(b)});
			r[b] = (pg < RES_EFF_V);
		end
		return r;
	endfunction

	// lowest clear bit of a word, with a found flag on top
	function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] w);
		logic [BIT_W:0] r;
		r = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!w[b]) begin
				r = {1'b1, BIT_W'(b)};
			end
		end
		return r;
	endfunction

	logic [2:0]          state_q;
	logic [WA_W-1:0]     clr_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [USED_W-1:0]   used_q;
	logic [WA_W-1:0]     scan_q;
	logic                scan_done_q;
	logic                eval_s1;
	logic [WA_W-1:0]     eval_addr_s1;
	logic [HIT_W-1:0]    hit_idx_q;
	logic [WA_W-1:0]     free_word_q;
	logic [BIT_W-1:0]    free_bit_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                rsp_valid_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [FREE_W-1:0]   rsp_free_q;

	logic [WORD_W-1:0]   scan_word;
	logic [BIT_W:0]      zero_hit;
	logic [ADDR_W-1:0]   offset;
	logic                is_null;
	logic                is_below;
	logic                is_range;
	logic [WA_W-1:0]     chk_word;
	logic [BIT_W-1:0]    chk_bit;
	logic                free_bit_set;
	logic [31:0]         free_pages_w;
	logic [FP_W-1:0]     free_pages;
	logic [FP_W+PB_SH-1:0] free_bytes_wide;
	logic                accept;
	logic                emit_go;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign emit_go   = (state_q == S_EMIT) && (!rsp_valid_q || rsp.ready);

	// reserved pages below the scan start count as used in the first word
	assign scan_word = ram_rdata | ((eval_addr_s1 == START_WORD) ? START_MASK : '0);
	assign zero_hit  = first_zero(scan_word);

	assign is_null  = (addr_q == '0);
	assign is_below = (addr_q < base);
	assign offset   = addr_q - base;
	assign is_range = (offset >= REGION_BYTES);
	assign chk_word = offset[PB_SH+BIT_W +: WA_W];
	assign chk_bit  = offset[PB_SH +: BIT_W];

	assign free_bit_set = ram_rdata[free_bit_q];

	assign free_pages_w    = (32'(used_q) <= 32'(PAGE_COUNT)) ?
		(32'(PAGE_COUNT) - 32'(used_q)) : 32'd0;
	assign free_pages      = free_pages_w[FP_W-1:0];
	assign free_bytes_wide = (FP_W+PB_SH)'(free_pages) << PB_SH;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = reset_word(clr_q);
		ram_re    = 1'b0;
		ram_raddr = scan_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_SCAN: begin
				ram_re = !scan_done_q;
				if (eval_s1 && zero_hit[BIT_W]) begin
					ram_we    = 1'b1;
					ram_waddr = eval_addr_s1;
					ram_wdata = ram_rdata | (WORD_W'(1) << zero_hit[BIT_W-1:0]);
				end
			end
			S_FREE_CHK: begin
				ram_re    = !is_null && !is_below && !is_range;
				ram_raddr = chk_word;
			end
			S_FREE_RD: begin
				ram_we    = free_bit_set;
				ram_waddr = free_word_q;
				ram_wdata = ram_rdata & ~(WORD_W'(1) << free_bit_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= USED_RESET;
			scan_done_q <= 1'b0;
			eval_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WA_W'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.operation == OP_FREE) begin
							state_q <= S_FREE_CHK;
						end else if (NO_SCAN) begin
							res_addr_q   <= '0;
							res_status_q <= ST_OOM;
							state_q      <= S_EMIT;
						end else begin
							scan_q      <= START_WORD;
							scan_done_q <= 1'b0;
							eval_s1     <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// reads go out one word a cycle, each evaluated in the cycle after its read
					eval_s1      <= ram_re;
					eval_addr_s1 <= scan_q;
					if (ram_re) begin
						if (scan_q == LAST_WORD) begin
							scan_done_q <= 1'b1;
						end else begin
							scan_q <= scan_q + WA_W'(1);
						end
					end
					if (eval_s1) begin
						if (zero_hit[BIT_W]) begin
							hit_idx_q <= {eval_addr_s1, zero_hit[BIT_W-1:0]};
							used_q    <= used_q + USED_W'(1);
							state_q   <= S_ALLOC;
						end else if (eval_addr_s1 == LAST_WORD) begin
							res_addr_q   <= '0;
							res_status_q <= ST_OOM;
							state_q      <= S_EMIT;
						end
					end
				end
				S_ALLOC: begin
					res_addr_q   <= base + (ADDR_W'(hit_idx_q) << PB_SH);
					res_status_q <= ST_OK;
					state_q      <= S_EMIT;
				end
				S_FREE_CHK: begin
					res_addr_q  <= '0;
					free_word_q <= chk_word;
					free_bit_q  <= chk_bit;
					if (is_null) begin
						res_status_q <= ST_NULL;
						state_q      <= S_EMIT;
					end else if (is_below) begin
						res_status_q <= ST_BELOW;
						state_q      <= S_EMIT;
					end else if (is_range) begin
						res_status_q <= ST_RANGE;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: begin
					if (free_bit_set) begin
						used_q       <= used_q - USED_W'(1);
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_ALREADY;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= req.free_address;
		end
		if (emit_go) begin
			rsp_addr_q   <= res_addr_q;
			rsp_status_q <= res_status_q;
			rsp_free_q   <= FREE_W'(free_bytes_wide);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.page_address = rsp_addr_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.free_bytes   = rsp_free_q;

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_allocator.sv
// Physical page allocator: one used bit per page in a word-wide map RAM, served by an
// APB-style base register. Request in, one result out per request, each waiting in an
// output register until taken. After reset a clearing pass over all PAGE_COUNT/64 map
// words (64 at the defaults) writes the reset pattern into the map and no request is
// accepted meanwhile; register writes are taken throughout. An allocate request reads
// the map one 64-bit word per cycle through the single read port of the map RAM,
// starting at the word that holds RESERVED_PAGES, until it finds a clear bit or passes
// the last word. A free request goes through address check, map read and write back,
// and result; a failed address check goes straight to the result. One request is
// in work at a time; the next is accepted once the current result has been loaded
// into the output register. The user must keep PAGE_BYTES a power of two and
// PAGE_COUNT a power of two of at least 512; the block does not check this.
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ram, bpa_cfg, bpa_ctrl
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int PAGE_COUNT     = DEF_PAGE_COUNT,
	parameter int PAGE_BYTES     = DEF_PAGE_BYTES,
	parameter int RESERVED_PAGES = DEF_RESERVED_PAGES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bpa_req_if.sink                    req,
	bpa_rsp_if.source                  rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int MAP_WORDS = PAGE_COUNT / WORD_W;
	localparam int WA_W      = $clog2(MAP_WORDS);

	logic [ADDR_W-1:0] base;
	logic              ram_we;
	logic [WA_W-1:0]   ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [WA_W-1:0]   ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	bpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.base    (base)
	);

	bpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bpa_ctrl #(
		.PAGE_COUNT     (PAGE_COUNT),
		.PAGE_BYTES     (PAGE_BYTES),
		.RESERVED_PAGES (RESERVED_PAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.base      (base),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

FILE: rtl/bpa_checker.sv
// bpa_checker: port-level assertions on the page allocator, bound to its top level
// depends on bpa_pkg and bitmap_page_allocator
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker import bpa_pkg::*; #(
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [ADDR_W-1:0]   rsp_page_address,
	input wire logic [STATUS_W-1:0] rsp_status,
	input wire logic [FREE_W-1:0]   rsp_free_bytes,
	input wire logic                psel,
	input wire logic                pready
);

	localparam int PB_SH = $clog2(PAGE_BYTES);

	// a stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page_address)
			&& $stable(rsp_status) && $stable(rsp_free_bytes))
		else $error("result changed while stalled");

	// only a successful allocation carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_page_address == '0)
		else $error("page address on failed request");

	// free bytes are whole pages
	a_free_pages: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_bytes[PB_SH-1:0] == '0)
		else $error("free bytes not a page multiple");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register port stalled");

endmodule

bind bitmap_page_allocator bpa_checker #(
	.PAGE_BYTES (PAGE_BYTES)
) u_bpa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_page_address (rsp.page_address),
	.rsp_status       (rsp.status),
	.rsp_free_bytes   (rsp.free_bytes),
	.psel             (psel),
	.pready           (pready)
);

`default_nettype wire

FILE: verif/testbench.sv
// testbench: self-checking bench for bitmap_page_allocator, driving allocate and free
// requests through the request channel and checking every result against a local bitmap
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if and the allocator rtl
`timescale 1ns / 1ps

module testbench;
	import bpa_pkg::*;

	localparam int PAGE_COUNT     = DEF_PAGE_COUNT;
	localparam int PAGE_BYTES     = DEF_PAGE_BYTES;
	localparam int RESERVED_PAGES = DEF_RESERVED_PAGES;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
	} page_request_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   page_address;
		logic [STATUS_W-1:0] status;
		logic [FREE_W-1:0]   free_bytes;
	} page_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();

	bitmap_page_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// local copy of the allocator state
	bit                page_used [PAGE_COUNT];
	logic [USED_W-1:0] pages_in_use;
	logic [ADDR_W-1:0] base_reg;

	page_request_t req_backlog [$];
	page_result_t  awaited_results [$];

	int error_count = 0;
	bit req_fire = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;
	int idle_pct = 15;
	bit hold_go = 1'b0;
	bit rsp_hold = 1'b0;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 40)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic logic [ADDR_W-1:0] rand48();
		logic [ADDR_W-1:0] v;
		v = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
		return v;
	endfunction

	function automatic logic [ADDR_W-1:0] page_at(input int idx, input int off);
		return base_reg + ADDR_W'(idx) * ADDR_W'(PAGE_BYTES) + ADDR_W'(off);
	endfunction

	function automatic int count_claimed();
		int n;
		n = 0;
		for (int i = RESERVED_PAGES; i < PAGE_COUNT; i++)
			if (page_used[i])
				n++;
		return n;
	endfunction

	// updates the local bitmap for one accepted request and returns the result it causes
	function automatic page_result_t apply_page_request(input logic op,
		input logic [ADDR_W-1:0] addr);
		page_result_t      r;
		logic [ADDR_W-1:0] idx;
		bit                found;
		int unsigned       left;
		r.page_address = '0;
		r.status = ST_OK;
		if (op == OP_ALLOC) begin
			found = 1'b0;
			for (int i = RESERVED_PAGES; i < PAGE_COUNT && !found; i++) begin
				if (!page_used[i]) begin
					page_used[i] = 1'b1;
					pages_in_use = pages_in_use + 1'b1;
					r.page_address = base_reg + ADDR_W'(i) * ADDR_W'(PAGE_BYTES);
					found = 1'b1;
				end
			end
			if (!found)
				r.status = ST_OOM;
		end else if (addr == '0) begin
			r.status = ST_NULL;
		end else if (addr < base_reg) begin
			r.status = ST_BELOW;
		end else begin
			idx = (addr - base_reg) / ADDR_W'(PAGE_BYTES);
			if (idx >= ADDR_W'(PAGE_COUNT)) begin
				r.status = ST_RANGE;
			end else if (!page_used[int'(idx)]) begin
				r.status = ST_ALREADY;
			end else begin
				page_used[int'(idx)] = 1'b0;
				pages_in_use = pages_in_use - 1'b1;
			end
		end
		left = (pages_in_use <= PAGE_COUNT) ? PAGE_COUNT - pages_in_use : 0;
		r.free_bytes = FREE_W'(longint'(left) * PAGE_BYTES);
		return r;
	endfunction

	// monitor: request acceptance and result checking
	always @(posedge clk) begin
		page_result_t got;
		page_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.page_address = rsp_ch.page_address;
			got.status = rsp_ch.status;
			got.free_bytes = rsp_ch.free_bytes;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result with no request outstanding, status %0d",
					got.status));
			end else begin
				want = awaited_results.pop_front();
				if (got.page_address !== want.page_address)
					report_mismatch($sformatf("page_address %h, want %h",
						got.page_address, want.page_address));
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.free_bytes !== want.free_bytes)
					report_mismatch($sformatf("free_bytes %0d, want %0d",
						got.free_bytes, want.free_bytes));
			end
		end
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		if (req_fire)
			awaited_results.push_back(apply_page_request(req_ch.operation, req_ch.free_address));
	end

	// request driver
	always @(negedge clk) begin
		page_request_t nxt;
		if (req_ch.valid && !req_fire) begin
			// request still offered, hold it
		end else if (src_gap > 0) begin
			req_ch.valid <= 1'b0;
			src_gap--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			src_gap = $urandom_range(0, 11);
		end else if (req_backlog.size() != 0) begin
			nxt = req_backlog.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.operation <= nxt.op;
			req_ch.free_address <= nxt.addr;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// result sink
	always @(negedge clk) begin
		if (rsp_hold) begin
			rsp_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			rsp_ch.ready <= 1'b0;
			sink_gap--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			rsp_ch.ready <= 1'b0;
			sink_gap = $urandom_range(0, 11);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// long receiver stall so the block backs up into the request channel
	initial begin
		wait (hold_go);
		rsp_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold = 1'b0;
	end

	task automatic queue_request(input logic op, input logic [ADDR_W-1:0] addr);
		page_request_t it;
		it.op = op;
		// allocate ignores the address, so send junk there
		it.addr = (op == OP_ALLOC) ? rand48() : addr;
		req_backlog.push_back(it);
	endtask

	task automatic settle();
		while (req_backlog.size() != 0 || req_ch.valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(8 * REG_BASE_ADDRESS);
		pwdata <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		base_reg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic queue_noise();
		logic [ADDR_W-1:0] a;
		case ($urandom_range(0, 3))
			0: a = '0;
			1: a = (base_reg != '0) ? rand48() % base_reg : rand48();
			2: a = page_at(PAGE_COUNT, 0) + ADDR_W'($urandom_range(0, 24'hFFFFFF));
			default: a = rand48();
		endcase
		queue_request(OP_FREE, a);
	endtask

	// mostly allocations and frees of pages likely to be in use, some bad addresses
	task automatic queue_random_mix(input int n);
		int est;
		int idx;
		int off;
		int sel;
		est = count_claimed();
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				queue_request(OP_ALLOC, '0);
				est++;
			end else if (sel < 80) begin
				if ($urandom_range(0, 9) == 0)
					idx = $urandom_range(0, RESERVED_PAGES - 1);
				else
					idx = RESERVED_PAGES + $urandom_range(0, 2 * est + 8);
				off = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, PAGE_BYTES - 1);
				queue_request(OP_FREE, page_at(idx, off));
				if (est > 0)
					est--;
			end else begin
				queue_noise();
			end
		end
	endtask

	// fill every page, run into out of memory, then free a few and allocate again
	task automatic queue_fill();
		int avail;
		avail = (PAGE_COUNT - RESERVED_PAGES) - count_claimed();
		for (int k = 0; k < avail + 4; k++) begin
			queue_request(OP_ALLOC, '0);
			if ($urandom_range(0, 99) == 0)
				queue_noise();
		end
		for (int k = 0; k < 40; k++)
			queue_request(OP_FREE, page_at($urandom_range(RESERVED_PAGES, PAGE_COUNT - 1),
				$urandom_range(0, PAGE_BYTES - 1)));
		for (int k = 0; k < 45; k++)
			queue_request(OP_ALLOC, '0);
	endtask

	function automatic logic [ADDR_W-1:0] random_base();
		logic [ADDR_W-1:0] b;
		b = rand48();
		if ($urandom_range(0, 1) == 0)
			b[11:0] = '0;
		return b;
	endfunction

	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.free_address = '0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < PAGE_COUNT; i++)
			page_used[i] = (i < RESERVED_PAGES);
		pages_in_use = USED_W'(RESERVED_PAGES);
		base_reg = BASE_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// base register at its reset value
		queue_request(OP_ALLOC, '0);
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, page_at(RESERVED_PAGES, 0));
		queue_request(OP_FREE, page_at(RESERVED_PAGES, 0));
		queue_request(OP_FREE, '0);
		queue_request(OP_FREE, base_reg - 1'b1);
		queue_request(OP_FREE, 48'd1);
		queue_request(OP_FREE, page_at(PAGE_COUNT, 0));
		queue_request(OP_FREE, '1);
		queue_request(OP_FREE, page_at(RESERVED_PAGES + 1, 12'hABC));
		queue_request(OP_FREE, page_at(0, 0));
		queue_request(OP_FREE, page_at(RESERVED_PAGES - 1, PAGE_BYTES - 1));
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, page_at(PAGE_COUNT - 1, PAGE_BYTES - 1));
		settle();

		// zero base: a zero address is still null
		write_base('0);
		queue_request(OP_FREE, '0);
		queue_request(OP_FREE, 48'd1);
		queue_request(OP_FREE, page_at(1, 0));
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, '1);
		settle();

		// top base: page addresses wrap
		write_base('1);
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, '1);
		queue_request(OP_FREE, '1 - 1'b1);
		queue_request(OP_FREE, '0);
		settle();

		write_base(random_base());
		idle_pct = 20;
		queue_random_mix(200);
		hold_go = 1'b1;
		settle();

		write_base('0);
		idle_pct = 8;
		queue_random_mix(200);
		settle();

		write_base(random_base());
		idle_pct = 10;
		queue_fill();
		settle();

		write_base(random_base());
		idle_pct = 30;
		queue_random_mix(200);
		settle();

		write_base(48'hFFFF_FF00_0000 + ADDR_W'($urandom_range(0, 24'hFFFFFF)));
		idle_pct = 15;
		queue_random_mix(200);
		settle();

		write_base(random_base());
		idle_pct = 5;
		queue_random_mix(200);
		settle();

		// last stretch with no idling on either side
		write_base(BASE_RESET);
		idle_pct = 0;
		queue_random_mix(200);
		settle();

		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#(25_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: bitmap_page_allocator.f
rtl/bpa_pkg.sv
rtl/bpa_req_if.sv
rtl/bpa_rsp_if.sv
rtl/bpa_ram.sv
rtl/bpa_cfg.sv
rtl/bpa_ctrl.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
verif/testbench.sv
